@@ rtl/wis_pkg.sv @@
package wis_pkg;

	localparam int ENTRIES   = 64;
	localparam int FRAC_BITS = 16;

	localparam int IN_W    = FRAC_BITS + 1;
	localparam int BOUND_W = FRAC_BITS + 4;
	localparam int ADDR_W  = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int IDX_W   = 6;
	localparam int ST_W    = 2;

	localparam logic [ST_W-1:0] ST_ADDED = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_HIT   = 2'd2;
	localparam logic [ST_W-1:0] ST_MISS  = 2'd3;

	localparam logic MODE_ADD  = 1'b0;
	localparam logic MODE_DRAW = 1'b1;

	// low IDX_W bits of a table address, zero-extended when the table is small
	function automatic logic [IDX_W-1:0] to_index(input logic [ADDR_W-1:0] a);
		logic [ADDR_W+IDX_W-1:0] w;
		w = {{IDX_W{1'b0}}, a};
		return w[IDX_W-1:0];
	endfunction

	// saturating cumulative bound
	function automatic logic [BOUND_W-1:0] sat_add(input logic [BOUND_W-1:0] b,
			input logic [IN_W-1:0] w);
		logic [BOUND_W:0] s;
		s = {1'b0, b} + {{(BOUND_W + 1 - IN_W){1'b0}}, w};
		return s[BOUND_W] ? {BOUND_W{1'b1}} : s[BOUND_W-1:0];
	endfunction

endpackage

@@ rtl/weighted_index_sampler_top.sv @@
// Weighted index sampler (roulette-wheel selection).
// Command channel: a transaction is taken at a rising edge with start high
// and busy low. mode 0 appends an entry whose cumulative bound is the last
// bound plus weight (saturating) unless full; mode 1 draws with random_value.
// Result channel: done pulses for one cycle with status and entry_index;
// the receiver cannot stall, so every result is taken in its done cycle.
// Throughput:
//   append: the result is registered for the cycle after the command; busy
//           stays low, so appends can be issued every cycle.
//   draw:   the bounds live in one single-port-read RAM and are scanned one
//           per cycle; the scan stops at the first hit or after the last
//           entry (a miss), and busy is high for the scan. An empty table
//           misses without a scan, in the cycle after the command.
// Reset (arst_n low) empties the table: entry count and last bound go to
// zero. RAM contents are not cleared; only written entries are ever read.
// A bound equal to the draw value belongs to no entry (strict compares).
module weighted_index_sampler_top
	import wis_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  logic [IN_W-1:0]    weight,
	input  logic [IN_W-1:0]    random_value,
	output logic               done,
	output logic [ST_W-1:0]    status,
	output logic [IDX_W-1:0]   entry_index
);

	typedef enum logic {IDLE, SCAN} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;      // entries appended
	logic [BOUND_W-1:0]  last_q;       // bound of the newest entry, zero if none
	logic [CNT_W-1:0]    rd_cnt_q;     // next address to read during a scan
	logic [IN_W-1:0]     rv_q;
	logic [BOUND_W-1:0]  prev_q;       // lower bound of the entry now compared
	logic                v_s1;         // read data valid this cycle
	logic [ADDR_W-1:0]   idx_s1;       // address of that read
	logic                done_q;
	logic [ST_W-1:0]     status_q;
	logic [IDX_W-1:0]    index_q;

	logic                take;
	logic                full;
	logic                ram_we;
	logic                ram_re;
	logic [BOUND_W-1:0]  new_bound;
	logic [BOUND_W-1:0]  rd_data;
	logic [BOUND_W-1:0]  rv_ext;
	logic                hit;
	logic                last_rd;

	assign take      = start && (state_q == IDLE);
	assign full      = (count_q == CNT_W'(ENTRIES));
	assign new_bound = sat_add(last_q, weight);
	assign ram_we    = take && (mode == MODE_ADD) && !full;
	assign ram_re    = (state_q == SCAN) && (rd_cnt_q < count_q);
	assign rv_ext    = {{(BOUND_W - IN_W){1'b0}}, rv_q};
	assign hit       = (prev_q < rv_ext) && (rv_ext < rd_data);
	assign last_rd   = ({1'b0, idx_s1} + CNT_W'(1)) == count_q;

	wis_ram #(
		.WIDTH(BOUND_W),
		.DEPTH(ENTRIES)
	) u_bounds (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(new_bound),
		.re   (ram_re),
		.raddr(rd_cnt_q[ADDR_W-1:0]),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			count_q  <= '0;
			last_q   <= '0;
			rd_cnt_q <= '0;
			v_s1     <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					v_s1   <= 1'b0;
					// appends and empty-table draws answer right away
					done_q <= take && ((mode == MODE_ADD) || (count_q == '0));
					if (take) begin
						if (mode == MODE_ADD) begin
							if (full) begin
								status_q <= ST_FULL;
								index_q  <= '0;
							end else begin
								status_q <= ST_ADDED;
								index_q  <= to_index(count_q[ADDR_W-1:0]);
								count_q  <= count_q + CNT_W'(1);
								last_q   <= new_bound;
							end
						end else if (count_q == '0) begin
							status_q <= ST_MISS;
							index_q  <= '0;
						end else begin
							state_q  <= SCAN;
							rv_q     <= random_value;
							prev_q   <= '0;
							rd_cnt_q <= '0;
						end
					end
				end
				SCAN: begin
					// issue the next read while the previous one is checked;
					// a stale v_s1 after the scan ends is cleared in IDLE
					v_s1   <= ram_re;
					done_q <= v_s1 && (hit || last_rd);
					if (ram_re) begin
						idx_s1   <= rd_cnt_q[ADDR_W-1:0];
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end
					if (v_s1) begin
						prev_q <= rd_data;
						if (hit) begin
							status_q <= ST_HIT;
							index_q  <= to_index(idx_s1);
							state_q  <= IDLE;
						end else if (last_rd) begin
							status_q <= ST_MISS;
							index_q  <= '0;
							state_q  <= IDLE;
						end
					end
				end
				default: begin
					state_q <= IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy        = (state_q != IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign entry_index = index_q;

endmodule

@@ rtl/wis_ram.sv @@
module wis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ dv/testbench.sv @@
typedef struct packed {
	logic [wis_pkg::ST_W-1:0]  status;
	logic [wis_pkg::IDX_W-1:0] index;
} sample_result_t;

// tracks the bound table and the queue of results still owed
class sampler_scoreboard;
	logic [wis_pkg::BOUND_W-1:0] bounds [wis_pkg::ENTRIES];
	int unsigned                 count;
	int unsigned                 errors;
	sample_result_t              owed_q[$];

	function new();
		count  = 0;
		errors = 0;
	endfunction

	function void note_command(input logic m, input logic [wis_pkg::IN_W-1:0] w,
			input logic [wis_pkg::IN_W-1:0] rv);
		sample_result_t              r;
		logic [wis_pkg::BOUND_W:0]   sum;
		logic [wis_pkg::BOUND_W-1:0] lower;
		logic [wis_pkg::BOUND_W-1:0] rv_ext;
		bit                          found;
		r.status = wis_pkg::ST_MISS;
		r.index  = '0;
		rv_ext   = {{(wis_pkg::BOUND_W - wis_pkg::IN_W){1'b0}}, rv};
		if (m == wis_pkg::MODE_ADD) begin
			if (count >= wis_pkg::ENTRIES) begin
				r.status = wis_pkg::ST_FULL;
			end else begin
				lower = (count == 0) ? '0 : bounds[count-1];
				sum   = {1'b0, lower} + {{(wis_pkg::BOUND_W + 1 - wis_pkg::IN_W){1'b0}}, w};
				// clamp to the top of the Q4 range
				if (sum > {1'b0, {wis_pkg::BOUND_W{1'b1}}})
					bounds[count] = {wis_pkg::BOUND_W{1'b1}};
				else
					bounds[count] = sum[wis_pkg::BOUND_W-1:0];
				r.status = wis_pkg::ST_ADDED;
				r.index  = count[wis_pkg::IDX_W-1:0];
				count++;
			end
		end else begin
			found = 1'b0;
			for (int i = 0; i < count; i++) begin
				lower = (i == 0) ? '0 : bounds[i-1];
				if (!found && rv_ext > lower && rv_ext < bounds[i]) begin
					found    = 1'b1;
					r.status = wis_pkg::ST_HIT;
					r.index  = i[wis_pkg::IDX_W-1:0];
				end
			end
		end
		owed_q.insert(owed_q.size(), r);
	endfunction

	function void check_result(input logic [wis_pkg::ST_W-1:0] st,
			input logic [wis_pkg::IDX_W-1:0] idx);
		sample_result_t e;
		if (owed_q.size() == 0) begin
			errors++;
			$display("%0t: unexpected result: status %0d entry_index %0d", $time, st, idx);
			return;
		end
		e = owed_q.pop_front();
		if (st !== e.status) begin
			errors++;
			$display("%0t: status mismatch: expected %0d actual %0d", $time, e.status, st);
		end
		if (idx !== e.index) begin
			errors++;
			$display("%0t: entry_index mismatch: expected %0d actual %0d",
				$time, e.index, idx);
		end
	endfunction
endclass

module testbench;
	import wis_pkg::*;

	// generous cycle cap: ~1700 transactions with sender gaps stay far below
	// this even if every one were a full-table draw scan
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int N_PHASES    = 4;
	localparam int PHASE_ITEMS = 412;
	localparam logic [IN_W-1:0] IN_MAX = {IN_W{1'b1}};
	localparam logic [IN_W-1:0] ONE_Q  = IN_W'(1) << FRAC_BITS;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             mode;
	logic [IN_W-1:0]  weight;
	logic [IN_W-1:0]  random_value;
	logic             done;
	logic [ST_W-1:0]  status;
	logic [IDX_W-1:0] entry_index;

	sampler_scoreboard sb = new();
	int unsigned       cycles = 0;
	int                idle_pct [N_PHASES] = '{0, 54, 0, 34};

	weighted_index_sampler_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.weight       (weight),
		.random_value (random_value),
		.done         (done),
		.status       (status),
		.entry_index  (entry_index)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Monitor: everything is sampled at the rising edge, before the block's
	// registers update. A transaction is taken when start is high and busy low;
	// a result is taken in its single done cycle (no back-pressure possible).
	always @(posedge clk) begin
		if (start === 1'b1 && busy === 1'b0)
			sb.note_command(mode, weight, random_value);
		if (done === 1'b1)
			sb.check_result(status, entry_index);
	end

	// run-away guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("weighted_index_sampler_top test failed");
			$finish;
		end
	end

	// Drive one command from a falling edge and hold it until the block takes
	// it. Returns at the next falling edge with start still high, so a
	// back-to-back command keeps start asserted without a glitch.
	task automatic send_command(input logic m, input logic [IN_W-1:0] w,
			input logic [IN_W-1:0] rv);
		mode         = m;
		weight       = w;
		random_value = rv;
		start        = 1'b1;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// one sender-idle cycle; payload ports carry junk the block must ignore
	task automatic idle_cycle();
		start        = 1'b0;
		mode         = 1'($urandom_range(0, 1));
		weight       = IN_W'($urandom_range(0, IN_MAX));
		random_value = IN_W'($urandom_range(0, IN_MAX));
		@(negedge clk);
	endtask

	initial begin
		logic            m;
		logic [IN_W-1:0] w;
		logic [IN_W-1:0] rv;
		int unsigned     pick;

		arst_n       = 1'b0;
		start        = 1'b0;
		mode         = MODE_ADD;
		weight       = '0;
		random_value = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed part ---
		// empty table: every draw misses
		send_command(MODE_DRAW, '0, '0);
		send_command(MODE_DRAW, '0, IN_MAX);
		// zero weight: entry 0 gets an empty interval [0,0]
		send_command(MODE_ADD, '0, '0);
		send_command(MODE_DRAW, '0, '0);
		// smallest nonzero weight, then draws on and beside the bound
		send_command(MODE_ADD, 17'd1, '0);
		send_command(MODE_DRAW, '0, 17'd1);
		send_command(MODE_DRAW, '0, 17'd2);
		// weight of exactly one
		send_command(MODE_ADD, ONE_Q, '0);
		send_command(MODE_DRAW, '0, ONE_Q >> 1);
		send_command(MODE_DRAW, '0, ONE_Q);
		send_command(MODE_DRAW, '0, ONE_Q + 17'd1);
		send_command(MODE_DRAW, '0, IN_MAX);
		// weight above one: all ones in the field
		send_command(MODE_ADD, IN_MAX, '0);
		send_command(MODE_DRAW, '0, IN_MAX);
		send_command(MODE_DRAW, '0, ONE_Q + 17'd2);
		// another zero weight repeats a bound; draws land on the earlier entry
		send_command(MODE_ADD, '0, IN_MAX);
		send_command(MODE_DRAW, '0, 17'h18000);
		// append followed directly by draw, then back-to-back appends
		send_command(MODE_ADD, 17'h00800, IN_MAX);
		send_command(MODE_DRAW, '0, '0);
		send_command(MODE_ADD, 17'h00400, '0);
		send_command(MODE_ADD, 17'h0AAAA, '0);
		send_command(MODE_DRAW, '0, 17'h15555);

		// --- random part ---
		// The table only grows, so it fills in the first phases: small weights
		// spread ~48 entries over [0,1], then large weights push the sum past
		// the Q4 top and saturate it. Later appends are refused as table full.
		for (int ph = 0; ph < N_PHASES; ph++) begin
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				while ($urandom_range(0, 99) < idle_pct[ph])
					idle_cycle();
				m  = ($urandom_range(0, 9) < ((sb.count < ENTRIES) ? 1 : 2)) ?
					MODE_ADD : MODE_DRAW;
				w  = IN_W'($urandom_range(0, IN_MAX));
				rv = IN_W'($urandom_range(0, IN_MAX));
				if (m == MODE_ADD) begin
					if (sb.count < 48)
						w = ($urandom_range(0, 15) == 0) ? '0 :
							IN_W'($urandom_range(0, 2500));
					else if (sb.count < ENTRIES)
						w = IN_W'($urandom_range(17'h08000, IN_MAX));
				end else begin
					pick = $urandom_range(0, 7);
					// aim at a stored bound, on it or one step either side
					if (pick < 2 && sb.count > 0)
						rv = IN_W'(sb.bounds[$urandom_range(0, sb.count - 1)] +
							$urandom_range(0, 2) - 1);
					else if (pick == 2)
						rv = ($urandom_range(0, 1) == 1) ? IN_MAX : '0;
					else if (pick == 3)
						rv = IN_W'($urandom_range(0, ONE_Q));
				end
				send_command(m, w, rv);
			end
		end
		start = 1'b0;

		// drain, then allow one more full scan for stray results
		while (sb.owed_q.size() != 0)
			@(posedge clk);
		repeat (ENTRIES + 8) @(posedge clk);

		if (sb.owed_q.size() != 0)
			$display("%0t: %0d expected results never arrived", $time, sb.owed_q.size());
		if (sb.errors == 0 && sb.owed_q.size() == 0) begin
			$display("weighted_index_sampler_top test passed");
		end else begin
			$display("weighted_index_sampler_top test failed");
		end
		$finish;
	end

endmodule
